/* design/vertex_set_center_and_scale_unit_defines.svh */
// Assertion macros for the vertex center and scale unit.
`ifndef VERTEX_SET_CENTER_AND_SCALE_UNIT_DEFINES_SVH
`define VERTEX_SET_CENTER_AND_SCALE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define VSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define VSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/vsc_pkg.sv */
// ----------------------------------------------------------------------
// vsc_pkg
// Shared types for the vertex center and scale unit.
// ----------------------------------------------------------------------
`default_nettype none
package vsc_pkg;
  typedef enum logic [3:0] {
    ST_LOAD, ST_CENTER, ST_DIST_RD, ST_DIST_ACC, ST_SQRT, ST_DIV,
    ST_OUT_RD, ST_OUT_MUL, ST_OUT_HOLD
  } vsc_state_e;

  typedef struct packed {
    logic load;     // store vertex / update box
    logic center;   // latch center, clear max
    logic dist_rd;  // issue store read for distance
    logic dist_acc; // accumulate distance of read entry
    logic sqrt_go;  // start root
    logic div_go;   // start divide
    logic out_rd;   // issue store read for output
    logic out_mul;  // compute output vertex
    logic clear;    // end of set
  } vsc_cmd_t;

  typedef struct packed {
    logic last_idx;  // read index at final entry
    logic res_last;  // result register holds the final entry
    logic empty;     // no vertex stored
    logic sqrt_done;
    logic div_done;
  } vsc_sts_t;
endpackage
`default_nettype wire

/* design/vsc_if.sv */
// ----------------------------------------------------------------------
// vsc_in_if / vsc_out_if
// Valid/ready channels for vertex requests and results.
// ----------------------------------------------------------------------
`default_nettype none
interface vsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic               is_last;
  modport source (output valid, coord_x, coord_y, coord_z, is_last, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, is_last, output ready);
endinterface

interface vsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               end_of_set;
  logic               overflowed;
  modport source (output valid, out_x, out_y, out_z, end_of_set, overflowed, input ready);
  modport sink (input valid, out_x, out_y, out_z, end_of_set, overflowed, output ready);
endinterface
`default_nettype wire

/* design/vsc_ctrl.sv */
// ----------------------------------------------------------------------
// vsc_ctrl
// Sequencer: load, center, distance pass, root, divide, output pass.
// ----------------------------------------------------------------------
`default_nettype none
module vsc_ctrl
  import vsc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_fire_i,
  input  wire logic     in_last_i,
  input  wire logic     out_fire_i,
  input  wire vsc_sts_t sts_i,
  output vsc_cmd_t      cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);
  vsc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:     if (in_fire_i && in_last_i) state_d = ST_CENTER;
      ST_CENTER:   state_d = sts_i.empty ? ST_LOAD : ST_DIST_RD;
      ST_DIST_RD:  state_d = ST_DIST_ACC;
      ST_DIST_ACC: state_d = sts_i.last_idx ? ST_SQRT : ST_DIST_RD;
      ST_SQRT:     if (sts_i.sqrt_done) state_d = ST_DIV;
      ST_DIV:      if (sts_i.div_done) state_d = ST_OUT_RD;
      ST_OUT_RD:   state_d = ST_OUT_MUL;
      ST_OUT_MUL:  state_d = ST_OUT_HOLD;
      ST_OUT_HOLD: if (out_fire_i) state_d = sts_i.res_last ? ST_LOAD : ST_OUT_RD;
      default:     state_d = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i;
      end
      ST_CENTER: begin
        cmd_o.center = 1'b1;
        cmd_o.clear = sts_i.empty;
      end
      ST_DIST_RD:  cmd_o.dist_rd = 1'b1;
      ST_DIST_ACC: begin
        cmd_o.dist_acc = 1'b1;
        cmd_o.sqrt_go = sts_i.last_idx;
      end
      ST_SQRT:     cmd_o.div_go = sts_i.sqrt_done;
      ST_DIV:      ;
      ST_OUT_RD:   cmd_o.out_rd = 1'b1;
      ST_OUT_MUL:  cmd_o.out_mul = 1'b1;
      ST_OUT_HOLD: begin
        out_valid_o = 1'b1;
        cmd_o.clear = out_fire_i && sts_i.res_last;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* design/vsc_datapath.sv */
// ----------------------------------------------------------------------
// vsc_datapath
// Vertex store, box, distance, serial root and divide, output scaling.
// ----------------------------------------------------------------------
`default_nettype none
module vsc_datapath
  import vsc_pkg::*;
#(
  parameter int MaxVertices = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire vsc_cmd_t    cmd_i,
  input  wire logic [15:0] half_width_i,
  input  wire logic [15:0] in_x_i,
  input  wire logic [15:0] in_y_i,
  input  wire logic [15:0] in_z_i,
  output vsc_sts_t         sts_o,
  output logic [15:0]      out_x_o,
  output logic [15:0]      out_y_o,
  output logic [15:0]      out_z_o,
  output logic             out_last_o,
  output logic             out_ovf_o
);
  localparam int AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CW = $clog2(MaxVertices + 1);

  logic [47:0]        mem [MaxVertices];
  logic [47:0]        rd_q;
  logic [CW-1:0]      cnt_q;
  logic [AW-1:0]      idx_q;
  logic               drop_q;
  logic signed [15:0] mn_q [3];
  logic signed [15:0] mx_q [3];
  logic signed [15:0] ctr_q [3];
  logic [35:0]        maxd_q;
  logic [15:0]        in_v [3];

  assign in_v[0] = in_x_i;
  assign in_v[1] = in_y_i;
  assign in_v[2] = in_z_i;

  wire logic full = (cnt_q == CW'(MaxVertices));
  wire logic [CW-1:0] idx_ext = CW'(idx_q);

  assign sts_o.last_idx = (idx_ext + CW'(1)) == cnt_q;
  assign sts_o.res_last = out_last_o;
  assign sts_o.empty = (cnt_q == '0);

  // vertex store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) mem[cnt_q[AW-1:0]] <= {in_z_i, in_y_i, in_x_i};
    if (cmd_i.dist_rd || cmd_i.out_rd) rd_q <= mem[idx_q];
  end

  // count, drop flag, box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      drop_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        mn_q[a] <= '0;
        mx_q[a] <= '0;
      end
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
      drop_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        mn_q[a] <= '0;
        mx_q[a] <= '0;
      end
    end else if (cmd_i.load) begin
      if (full) drop_q <= 1'b1;
      else begin
        cnt_q <= cnt_q + CW'(1);
        for (int a = 0; a < 3; a++) begin
          if (cnt_q == '0 || $signed(in_v[a]) < mn_q[a]) mn_q[a] <= $signed(in_v[a]);
          if (cnt_q == '0 || $signed(in_v[a]) > mx_q[a]) mx_q[a] <= $signed(in_v[a]);
        end
      end
    end
  end

  // read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (cmd_i.center || cmd_i.clear) idx_q <= '0;
    else if (cmd_i.dist_acc || cmd_i.out_mul) idx_q <= sts_o.last_idx ? '0 : idx_q + AW'(1);
  end

  // differences of the read entry
  logic signed [17:0] dif [3];
  always_comb begin
    for (int a = 0; a < 3; a++)
      dif[a] = 18'($signed(rd_q[16*a +: 16])) - 18'(ctr_q[a]);
  end

  // center, distance maximum
  logic [35:0] d2;
  always_comb begin
    logic signed [35:0] dw;
    d2 = '0;
    for (int a = 0; a < 3; a++) begin
      dw = 36'(dif[a]);
      d2 = d2 + 36'(dw * dw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.center) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [16:0] s;
        s = 17'(mx_q[a]) + 17'(mn_q[a]);
        ctr_q[a] <= s[16:1];
      end
      maxd_q <= '0;
    end else if (cmd_i.dist_acc && d2 > maxd_q) maxd_q <= d2;
  end

  // serial root: one result bit per cycle
  logic [35:0] rem_q;
  logic [17:0] root_q;
  logic [4:0]  sc_q;
  logic        sbusy_q;
  logic [35:0] rem_sh, trial;
  assign rem_sh = {rem_q[33:0], maxd_q[35 - 2*sc_q -: 2]};
  assign trial = {16'd0, root_q, 2'b01};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sc_q <= '0;
    end else if (cmd_i.sqrt_go) begin
      sbusy_q <= 1'b1;
      sc_q <= '0;
    end else if (sbusy_q) begin
      sc_q <= sc_q + 5'd1;
      if (sc_q == 5'd17) sbusy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      rem_q <= '0;
      root_q <= '0;
    end else if (sbusy_q) begin
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        root_q <= {root_q[16:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        root_q <= {root_q[16:0], 1'b0};
      end
    end
  end
  assign sts_o.sqrt_done = !sbusy_q && !cmd_i.sqrt_go && sc_q == 5'd18;

  // serial divide: (half_width << 16) / root, restoring, 32 quotient bits
  logic [31:0] quo_q;
  logic [18:0] drem_q;
  logic [5:0]  dc_q;
  logic        dbusy_q;
  logic [31:0] dvd;
  logic [18:0] dsh;
  assign dvd = {half_width_i, 16'd0};
  assign dsh = {drem_q[17:0], dvd[5'(31 - dc_q[4:0])]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dc_q <= '0;
    end else if (cmd_i.div_go) begin
      dbusy_q <= 1'b1;
      dc_q <= '0;
    end else if (dbusy_q) begin
      dc_q <= dc_q + 6'd1;
      if (dc_q == 6'd31) dbusy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      drem_q <= '0;
      quo_q <= '0;
    end else if (dbusy_q) begin
      if (root_q == '0) quo_q <= '0;
      else if (dsh >= {1'b0, root_q}) begin
        drem_q <= dsh - {1'b0, root_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        drem_q <= dsh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = !dbusy_q && !cmd_i.div_go && dc_q == 6'd32;

  // output scaling, registered result
  logic [15:0] res [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [17:0] mag;
      logic [49:0] p;
      logic [33:0] q;
      mag = dif[a][17] ? 18'(-dif[a]) : 18'(dif[a]);
      p = 50'(mag) * 50'(quo_q);
      q = p[49:16];
      if (dif[a][17]) res[a] = (q > 34'd32768) ? 16'h8000 : 16'(-q);
      else res[a] = (q > 34'd32767) ? 16'h7fff : q[15:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_mul) begin
      out_x_o <= res[0];
      out_y_o <= res[1];
      out_z_o <= res[2];
      out_last_o <= sts_o.last_idx;
      out_ovf_o <= drop_q;
    end
  end
endmodule
`default_nettype wire

/* design/vertex_set_center_and_scale_unit.sv */
// ----------------------------------------------------------------------
// vertex_set_center_and_scale_unit
// Centers a vertex set on its box and scales it to a target sphere.
// ----------------------------------------------------------------------
// Usage: vertex requests enter on in_if (valid/ready), one per cycle while
// loading. A request with is_last starts processing: center, a distance
// pass over the stored vertices, a bit-serial root and a serial divide
// (each signalling done when finished), then an output pass per vertex
// that waits on any receiver stall. Input is not accepted during
// processing. Both passes go through the shared store read port. A
// stalled receiver holds the result register and the controller waits.
// The user must write half_width with cfg_we_i only while idle; the block
// does not enforce this. Reset empties the set and sets half_width to
// 1.0 (256); store contents are not cleared and are never read before
// being written.
// ----------------------------------------------------------------------
`default_nettype none
`include "vertex_set_center_and_scale_unit_defines.svh"
module vertex_set_center_and_scale_unit
  import vsc_pkg::*;
#(
  parameter int MaxVertices = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  vsc_in_if.sink           in_if,
  vsc_out_if.source        out_if
);
  vsc_cmd_t    cmd;
  vsc_sts_t    sts;
  logic [15:0] half_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) half_width_q <= 16'd256;
    else if (cfg_we_i) half_width_q <= cfg_wdata_i;
  end

  wire logic in_fire = in_if.valid && in_if.ready;
  wire logic out_fire = out_if.valid && out_if.ready;

  vsc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire), .in_last_i(in_if.is_last), .out_fire_i(out_fire),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o(in_if.ready), .out_valid_o(out_if.valid)
  );

  vsc_datapath #(.MaxVertices(MaxVertices)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .half_width_i(half_width_q),
    .in_x_i(in_if.coord_x), .in_y_i(in_if.coord_y), .in_z_i(in_if.coord_z),
    .sts_o(sts), .out_x_o(out_if.out_x), .out_y_o(out_if.out_y),
    .out_z_o(out_if.out_z), .out_last_o(out_if.end_of_set),
    .out_ovf_o(out_if.overflowed)
  );

  // no input taken while a result is pending
  `VSC_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_if.valid, !in_if.ready)
  // result held until taken
  `VSC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid)
  // root and divide never run together
  `VSC_ASSERT_IMPL(a_excl, clk_i, rst_ni, cmd.div_go, !cmd.sqrt_go)
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex center and scale unit. Vertex sets
// are sent over the request channel and the normalized vertices that
// come back are checked, in order, against an in-bench bounding-box and
// sphere-scaling predictor. A short table of directed sets comes first,
// then random sets under several half_width settings. Both channels
// stall at random.
// ----------------------------------------------------------------------
`default_nettype none
module tb_top;
  import vsc_pkg::*;

  localparam int SetCapacity = 64;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 80;
  localparam int StallCycles = 600;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } vertex_req_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               eos;
    logic               ovf;
  } norm_vertex_t;

  // Directed row: one request, plus an optional hand-written result.
  typedef struct {
    vertex_req_t  req;
    logic         typed;
    norm_vertex_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  vsc_in_if  in_if ();
  vsc_out_if out_if ();

  vertex_set_center_and_scale_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: mirrors the stored set and the scale register
  logic [15:0]  half_width_q;
  logic [47:0]  set_store [SetCapacity];
  int           set_count;
  int           box_lo [3];
  int           box_hi [3];
  logic         set_dropped;
  norm_vertex_t pending_q [$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  idle_en = 1'b1;
  int  sink_hold = 0;
  bit  stall_req = 1'b0;
  bit  stall_taken = 1'b0;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void clear_set();
    set_count = 0;
    set_dropped = 1'b0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 40;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] scale_coord(input int d, input longint unsigned coef);
    longint unsigned mag = (d < 0) ? longint'(-d) : longint'(d);
    longint unsigned q = (mag * coef) >> 16;
    if (d < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  // Accept one vertex; on the last one, append the normalized set when push is set.
  function automatic void center_and_scale(input vertex_req_t v, input bit push);
    int vals [3];
    int ctr [3];
    longint unsigned maxd2 = 0;
    longint unsigned radius, coef, d2;
    int d;
    norm_vertex_t r;
    vals[0] = v.x; vals[1] = v.y; vals[2] = v.z;
    if (set_count < SetCapacity) begin
      set_store[set_count] = {v.z, v.y, v.x};
      for (int a = 0; a < 3; a++) begin
        if (set_count == 0 || vals[a] < box_lo[a]) box_lo[a] = vals[a];
        if (set_count == 0 || vals[a] > box_hi[a]) box_hi[a] = vals[a];
      end
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!v.last) return;
    for (int a = 0; a < 3; a++) ctr[a] = (box_hi[a] + box_lo[a]) >>> 1;
    for (int i = 0; i < set_count; i++) begin
      d2 = 0;
      for (int a = 0; a < 3; a++) begin
        d = int'($signed(set_store[i][16*a +: 16])) - ctr[a];
        d2 += longint'(d) * longint'(d);
      end
      if (d2 > maxd2) maxd2 = d2;
    end
    radius = int_sqrt(maxd2);
    coef = (radius == 0) ? 0 : ((longint'(half_width_q) << 16) / radius);
    for (int i = 0; i < set_count; i++) begin
      r.x = scale_coord(int'($signed(set_store[i][15:0])) - ctr[0], coef);
      r.y = scale_coord(int'($signed(set_store[i][31:16])) - ctr[1], coef);
      r.z = scale_coord(int'($signed(set_store[i][47:32])) - ctr[2], coef);
      r.eos = (i + 1 == set_count);
      r.ovf = set_dropped;
      if (push) pending_q.push_back(r);
    end
    clear_set();
  endfunction

  // Request side: drive one vertex and wait for its handshake
  task automatic send_vertex(input vertex_req_t v);
    if (idle_en && $urandom_range(99) < 56) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.coord_x <= v.x;
    in_if.coord_y <= v.y;
    in_if.coord_z <= v.z;
    in_if.is_last <= v.last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_predicted(input vertex_req_t v);
    send_vertex(v);
    center_and_scale(v, 1'b1);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_half_width(input logic [15:0] hw);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    half_width_q = hw;
  endtask

  function automatic vertex_req_t rand_vertex(input bit clustered, input int base[3]);
    vertex_req_t v;
    if (clustered) begin
      v.x = 16'(base[0] + $signed($urandom_range(0, 1023)) - 512);
      v.y = 16'(base[1] + $signed($urandom_range(0, 1023)) - 512);
      v.z = 16'(base[2] + $signed($urandom_range(0, 1023)) - 512);
    end else begin
      v.x = 16'($urandom);
      v.y = 16'($urandom);
      v.z = 16'($urandom);
    end
    v.last = 1'b0;
    return v;
  endfunction

  task automatic send_random_set(input int n, input bit flat);
    int base [3];
    bit clustered = $urandom_range(1);
    vertex_req_t v;
    for (int a = 0; a < 3; a++) base[a] = $signed($urandom_range(0, 40000)) - 20000;
    v = rand_vertex(clustered, base);
    for (int i = 0; i < n; i++) begin
      if (!flat) v = rand_vertex(clustered, base);
      v.last = (i == n - 1);
      send_predicted(v);
    end
  endtask

  // Result side: check each accepted result
  always @(posedge clk_i) begin
    norm_vertex_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        e = pending_q.pop_front();
        if (out_if.out_x !== e.x)
          report_mismatch($sformatf("out_x %0d exp %0d", out_if.out_x, e.x));
        if (out_if.out_y !== e.y)
          report_mismatch($sformatf("out_y %0d exp %0d", out_if.out_y, e.y));
        if (out_if.out_z !== e.z)
          report_mismatch($sformatf("out_z %0d exp %0d", out_if.out_z, e.z));
        if (out_if.end_of_set !== e.eos)
          report_mismatch($sformatf("end_of_set %0b exp %0b", out_if.end_of_set, e.eos));
        if (out_if.overflowed !== e.ovf)
          report_mismatch($sformatf("overflowed %0b exp %0b", out_if.overflowed, e.ovf));
      end
    end
  end

  // Result side ready: one long hold counted here, otherwise random idling
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_if.ready <= 1'b0;
    end else if (stall_req && !stall_taken) begin
      sink_hold <= StallCycles;
      stall_taken <= 1'b1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(idle_en && $urandom_range(99) < 36);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  dir_row_t dir_tbl [$];

  function automatic dir_row_t row(input int x, input int y, input int z, input bit last,
                                   input bit typed = 0, input int ex = 0, input int ey = 0,
                                   input int ez = 0, input bit eos = 0);
    dir_row_t r;
    r.req = '{16'(x), 16'(y), 16'(z), last};
    r.typed = typed;
    r.res = '{16'(ex), 16'(ey), 16'(ez), eos, 1'b0};
    return r;
  endfunction

  initial begin
    vertex_req_t v;
    in_if.valid   = 1'b0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    in_if.is_last = 1'b0;
    half_width_q  = 16'd256;
    clear_set();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets at the reset scale
    dir_tbl.push_back(row(0, 0, 0, 1, 1, 0, 0, 0, 1));
    dir_tbl.push_back(row(-32768, 32767, -32768, 1, 1, 0, 0, 0, 1));
    dir_tbl.push_back(row(100, 100, 100, 0, 1, 0, 0, 0, 0));
    dir_tbl.push_back(row(100, 100, 100, 1, 1, 0, 0, 0, 1));
    dir_tbl.push_back(row(-32768, -32768, -32768, 0));
    dir_tbl.push_back(row(32767, 32767, 32767, 1));
    dir_tbl.push_back(row(-32768, 32767, 0, 0));
    dir_tbl.push_back(row(32767, -32768, 0, 1));
    dir_tbl.push_back(row(256, 0, 0, 0));
    dir_tbl.push_back(row(-256, 0, 0, 0));
    dir_tbl.push_back(row(0, 512, -512, 1));
    dir_tbl.push_back(row(1, -1, 0, 0));
    dir_tbl.push_back(row(-1, 1, 0, 0));
    dir_tbl.push_back(row(0, 0, 1, 1));
    foreach (dir_tbl[i]) begin
      send_vertex(dir_tbl[i].req);
      center_and_scale(dir_tbl[i].req, !dir_tbl[i].typed);
      if (dir_tbl[i].typed) pending_q.push_back(dir_tbl[i].res);
    end
    drain_results();

    // Scale extremes on random sets; at the largest scale outputs saturate
    write_half_width(16'hFFFF);
    for (int i = 0; i < 4; i++) send_random_set($urandom_range(2, 5), 0);
    drain_results();
    write_half_width(16'h0000);
    send_random_set(3, 0);
    send_random_set(2, 0);
    drain_results();

    // Capacity: two over, so the dropped vertices include the last one
    write_half_width(16'h0100);
    send_random_set(SetCapacity + 2, 0);
    drain_results();

    // Long result stall while the next set keeps offering requests
    stall_req = 1'b1;
    send_random_set(20, 0);
    send_random_set(4, 0);
    drain_results();

    // Random phases at several scales; one phase without idling
    for (int ph = 0; ph < 4; ph++) begin
      write_half_width((ph == 3) ? 16'($urandom) : 16'($urandom_range(16, 2048)));
      idle_en = (ph != 2);
      for (int s = 0; s < 5; s++) begin
        if ($urandom_range(9) == 0) send_random_set($urandom_range(2, 4), 1);
        else send_random_set($urandom_range(1, 8), 0);
      end
      drain_results();
    end
    idle_en = 1'b1;

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
